// File: hw/rtl/ffd_pkg.sv
package ffd_pkg;

  localparam int NUM_OUT = 6;
  localparam logic [7:0] SYNC0 = 8'hAA;
  localparam logic [7:0] SYNC1 = 8'h55;
  localparam int ACC_W = 56;

  typedef enum logic [7:0] {
    PH_HUNT  = 8'b00000001,
    PH_SYNC  = 8'b00000010,
    PH_LENH  = 8'b00000100,
    PH_LENL  = 8'b00001000,
    PH_SEQH  = 8'b00010000,
    PH_SEQL  = 8'b00100000,
    PH_DATA  = 8'b01000000,
    PH_CHECK = 8'b10000000
  } phase_t;

  typedef struct packed {
    logic       clear;
    logic       load_high;
    logic       mac_start;
    logic       emit;
  } dp_cmd_t;

  typedef struct packed {
    logic busy;
    logic out_full;
  } dp_status_t;

  function automatic logic signed [31:0] coef(input logic [2:0] r, input logic [2:0] c);
    logic signed [31:0] t [0:35];
    t = '{ 32'sd201756,   32'sd236448,    32'sd565394,   32'sd19039266, 32'sd82895,    -32'sd18752590,
           32'sd113785,   -32'sd21270045, 32'sd505071,   32'sd11226849, 32'sd313222,   32'sd10579545,
           32'sd59427636, -32'sd349105,   32'sd59198416, 32'sd1193544,  32'sd57902991, -32'sd1052261,
           -32'sd34801,   -32'sd14632,    -32'sd326691,  32'sd3800,     32'sd265680,   32'sd5256,
           32'sd366842,   32'sd157,       -32'sd139500,  -32'sd17968,   -32'sd151996,  32'sd18676,
           32'sd74,       32'sd133058,    32'sd3800,     32'sd125500,   -32'sd469,     32'sd91908 };
    if (r > 3'd5 || c > 3'd5) return 32'sd0;
    return t[{3'd0, r} * 6'd6 + {3'd0, c}];
  endfunction

endpackage

// File: hw/rtl/ffd_ctrl.sv
module ffd_ctrl #(
  parameter int CHANNELS = 6
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_fire,
  input  logic [7:0]           rx_byte,
  input  logic [7:0]           running_sum,
  input  ffd_pkg::dp_status_t  status,
  output logic                 in_ready,
  output ffd_pkg::dp_cmd_t     cmd,
  output logic [3:0]           channel,
  output logic                 seq_hi_we,
  output logic                 seq_lo_we,
  output logic                 sum_we
);
  localparam int NB = 2 * CHANNELS;
  localparam int LEN = 2 * CHANNELS + 3;

  ffd_pkg::phase_t phase, phase_next;
  logic [7:0] length_high;
  logic [4:0] byte_count;
  logic [7:0] len_low_chk;

  assign in_ready = !status.busy && !(phase == ffd_pkg::PH_CHECK && status.out_full);
  assign channel = byte_count[4:1];
  assign len_low_chk = 8'(LEN);
  assign seq_hi_we = (phase == ffd_pkg::PH_SEQH);
  assign seq_lo_we = (phase == ffd_pkg::PH_SEQL);
  assign sum_we = (phase == ffd_pkg::PH_DATA);

  function automatic ffd_pkg::phase_t resume(input logic [7:0] b);
    return (b == ffd_pkg::SYNC0) ? ffd_pkg::PH_SYNC : ffd_pkg::PH_HUNT;
  endfunction

  always_comb begin
    phase_next = phase;
    cmd = '0;
    if (in_fire) begin
      case (phase)
        ffd_pkg::PH_HUNT: phase_next = resume(rx_byte);
        ffd_pkg::PH_SYNC: phase_next = (rx_byte == ffd_pkg::SYNC1) ? ffd_pkg::PH_LENH
                                                                   : resume(rx_byte);
        ffd_pkg::PH_LENH: phase_next = ffd_pkg::PH_LENL;
        ffd_pkg::PH_LENL: begin
          if (length_high == 8'd0 && rx_byte == len_low_chk) begin
            phase_next = ffd_pkg::PH_SEQH;
            cmd.clear = 1'b1;
          end else begin
            phase_next = resume(rx_byte);
          end
        end
        ffd_pkg::PH_SEQH: phase_next = ffd_pkg::PH_SEQL;
        ffd_pkg::PH_SEQL: phase_next = ffd_pkg::PH_DATA;
        ffd_pkg::PH_DATA: begin
          if (!byte_count[0]) cmd.load_high = 1'b1;
          else if (byte_count[4:1] < 4'd6) cmd.mac_start = 1'b1;
          if (byte_count == 5'(NB - 1)) phase_next = ffd_pkg::PH_CHECK;
        end
        ffd_pkg::PH_CHECK: begin
          phase_next = resume(rx_byte);
          cmd.emit = (rx_byte == running_sum);
        end
        default: phase_next = ffd_pkg::PH_HUNT;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= ffd_pkg::PH_HUNT;
      length_high <= '0;
      byte_count <= '0;
    end else begin
      phase <= phase_next;
      if (in_fire && phase == ffd_pkg::PH_LENH) length_high <= rx_byte;
      if (in_fire && phase == ffd_pkg::PH_SEQL) byte_count <= '0;
      else if (in_fire && phase == ffd_pkg::PH_DATA) byte_count <= byte_count + 5'd1;
    end
  end

  a_emit_only_check: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> phase == ffd_pkg::PH_CHECK) else $error("emit outside check");
  a_mac_data: assert property (@(posedge clk) disable iff (rst)
    cmd.mac_start |-> phase == ffd_pkg::PH_DATA && byte_count[0]) else $error("bad mac");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    status.busy |-> !in_ready) else $error("accept while busy");
endmodule

// File: hw/rtl/ffd_datapath.sv
module ffd_datapath #(
  parameter int COEFF_FRAC_BITS = 32,
  parameter int OUT_FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_fire,
  input  logic [7:0]           rx_byte,
  input  ffd_pkg::dp_cmd_t     cmd,
  input  logic [3:0]           channel,
  input  logic                 seq_hi_we,
  input  logic                 seq_lo_we,
  input  logic                 sum_we,
  input  logic [95:0]          zero_flat,
  input  logic                 out_take,
  output logic [7:0]           running_sum,
  output ffd_pkg::dp_status_t  status,
  output logic                 out_valid,
  output logic [239:0]         out_data
);
  localparam int D = COEFF_FRAC_BITS - 32;
  localparam int DP = (D > 0) ? D : 0;
  localparam int ND = (D < 0) ? -D : 1;
  localparam int S = COEFF_FRAC_BITS - OUT_FRAC_BITS;
  localparam int AW = 40 + COEFF_FRAC_BITS;

  logic signed [AW-1:0] acc [0:5];
  logic [7:0]  high_byte;
  logic [15:0] seq;
  logic signed [16:0] diff;
  logic [2:0]  ch_r, row;
  logic        run, prod_v;
  logic [2:0]  prod_row;
  logic signed [49:0] prod;
  logic signed [31:0] bias;
  logic bias_taken;

  // coefficients with fewer fraction bits are rounded before the multiply
  function automatic logic signed [31:0] scale_coef(input logic signed [31:0] t);
    logic signed [32:0] w;
    w = 33'(t);
    if (D >= 0) return t;
    w = (w + (33'sd1 <<< (ND - 1))) >>> ND;
    return w[31:0];
  endfunction

  function automatic logic signed [31:0] to_out(input logic signed [AW-1:0] a);
    logic signed [AW-1:0] v;
    v = (a + (AW'(1) <<< (S - 1))) >>> S;
    if (v > AW'(32'sh7fffffff)) return 32'sh7fffffff;
    if (v < -AW'(33'sh080000000)) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] sat(input logic signed [32:0] v);
    if (v > 33'sh07fffffff) return 32'sh7fffffff;
    if (v < -33'sh080000000) return 32'sh80000000;
    return v[31:0];
  endfunction

  assign status.busy = run || prod_v;
  assign status.out_full = out_valid;

  // extra coefficient fraction bits are a plain left shift of the product
  logic signed [AW-1:0] cprod;
  assign cprod = AW'(prod) <<< DP;

  logic signed [31:0] v [0:5];
  always_comb for (int r = 0; r < 6; r++) v[r] = to_out(acc[r]);

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0; prod_v <= 1'b0; out_valid <= 1'b0; bias_taken <= 1'b0;
      bias <= '0; running_sum <= '0;
      for (int r = 0; r < 6; r++) acc[r] <= '0;
    end else begin
      if (out_take) out_valid <= 1'b0;
      if (in_fire && seq_hi_we) seq[15:8] <= rx_byte;
      if (in_fire && seq_lo_we) seq[7:0] <= rx_byte;
      if (in_fire && sum_we) running_sum <= running_sum + rx_byte;
      if (cmd.load_high) high_byte <= rx_byte;
      if (cmd.clear) begin
        running_sum <= '0;
        for (int r = 0; r < 6; r++) acc[r] <= '0;
      end
      if (cmd.mac_start) begin
        diff <= $signed({1'b0, high_byte, rx_byte}) - $signed({1'b0, zero_flat[channel*16 +: 16]});
        ch_r <= channel[2:0];
        row <= '0;
        run <= 1'b1;
      end
      prod_v <= run;
      if (run) begin
        prod <= diff * scale_coef(ffd_pkg::coef(row, ch_r));
        prod_row <= row;
        row <= row + 3'd1;
        if (row == 3'd5) run <= 1'b0;
      end
      if (prod_v) acc[prod_row] <= acc[prod_row] + cprod;
      if (cmd.emit) begin
        out_valid <= 1'b1;
        out_data[191:0] <= {v[5], v[4], v[3], v[2], v[1], v[0]};
        out_data[239:224] <= seq;
        if (!bias_taken) begin
          bias <= v[2]; bias_taken <= 1'b1;
          out_data[223:192] <= '0;
        end else begin
          out_data[223:192] <= sat(33'(v[2]) - 33'(bias));
        end
      end
    end
  end

  a_row_range: assert property (@(posedge clk) disable iff (rst)
    run |-> row <= 3'd5) else $error("row overrun");
  a_no_emit_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> !status.busy) else $error("emit while mac busy");
  a_prod_follows: assert property (@(posedge clk) disable iff (rst)
    prod_v |-> $past(run)) else $error("stray product");
endmodule

// File: hw/rtl/force_frame_decoupler_core.sv
// Force sensor frame decoder.
// s_axis: one received serial byte per item (tdata[7:0] = rx_byte).
// m_axis: one item per good frame, tdata from bit 0 up: force_x, force_y,
// force_z, moment_x, moment_y, moment_z, force_z_relative (32 bits each),
// frame_number (16 bits); 240 bits in all.
// cfg: writes zero-load counts, index 0..5 selects the channel.
// Every byte is taken at once except the second byte of each channel,
// which starts six multiply-accumulates on one shared 32x17 multiplier:
// s_axis_tready drops after it until all six products are accumulated. A
// good checksum byte produces the result in the cycle after acceptance; a stalled
// result holds m_axis and the next checksum byte waits, other bytes continue.
// Reset: parser hunts for the header, accumulators clear, zero counts return
// to their default values, the Fz reference is retaken from the next good
// frame.
module force_frame_decoupler_core #(
  parameter int CHANNELS = 6,
  parameter int COEFF_FRAC_BITS = 32,
  parameter int OUT_FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // rx_byte
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [239:0] m_axis_tdata,   // fx,fy,fz,mx,my,mz,fz_rel,frame_number
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [15:0]  cfg_data
);
  ffd_pkg::dp_cmd_t cmd;
  ffd_pkg::dp_status_t status;
  logic [3:0] channel;
  logic [7:0] running_sum;
  logic in_fire;
  logic [15:0] zero [0:5];
  logic [95:0] zero_flat;

  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign cfg_ready = 1'b1;
  assign zero_flat = {zero[5], zero[4], zero[3], zero[2], zero[1], zero[0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      zero[0] <= 16'd32716; zero[1] <= 16'd32764; zero[2] <= 16'd32761;
      zero[3] <= 16'd32800; zero[4] <= 16'd32683; zero[5] <= 16'd32672;
    end else if (cfg_valid && cfg_index < 3'd6) begin
      zero[cfg_index] <= cfg_data;
    end
  end

  logic seq_hi_we, seq_lo_we, sum_we;
  ffd_ctrl #(.CHANNELS(CHANNELS)) u_ctrl (
    .clk, .rst, .in_fire, .rx_byte(s_axis_tdata), .running_sum, .status,
    .in_ready(s_axis_tready), .cmd, .channel, .seq_hi_we, .seq_lo_we, .sum_we
  );

  ffd_datapath #(.COEFF_FRAC_BITS(COEFF_FRAC_BITS), .OUT_FRAC_BITS(OUT_FRAC_BITS)) u_dp (
    .clk, .rst, .in_fire, .rx_byte(s_axis_tdata), .cmd, .channel,
    .seq_hi_we, .seq_lo_we, .sum_we, .zero_flat,
    .out_take(m_axis_tvalid && m_axis_tready), .running_sum, .status,
    .out_valid(m_axis_tvalid), .out_data(m_axis_tdata)
  );
endmodule
